FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define LMBPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Clocked check that also holds through reset.
`define LMBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/lmbps_pkg.sv
// Shared types and constants for the LED matrix bit-plane scanner.
`timescale 1ns / 1ps
`default_nettype none
package lmbps_pkg;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PERIOD  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE0_PERIOD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE1_PERIOD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE2_PERIOD = 4'd3;

  localparam logic [7:0] RST_FIRST_PERIOD  = 8'h30;
  localparam logic [7:0] RST_PLANE0_PERIOD = 8'd7;
  localparam logic [7:0] RST_PLANE1_PERIOD = 8'd20;
  localparam logic [7:0] RST_PLANE2_PERIOD = 8'd40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic load;
    logic emit;
    logic next_byte;
  } ctl_cmd_t;

  typedef struct packed {
    logic tick_match;
    logic bit_end;
    logic byte_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/lmbps_ctrl.sv
// Scan controller: sequences fetch, load and shift of one line.
`timescale 1ns / 1ps
`default_nettype none
module lmbps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lmbps_pkg::dp_stat_t stat,
  output lmbps_pkg::ctl_cmd_t      cmd
);
  import lmbps_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && stat.tick_match) begin
          cmd.start = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.bit_end) begin
            if (stat.byte_end) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.next_byte = 1'b1;
              state_nxt     = ST_FETCH;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/lmbps_dp.sv
// Scan datapath: frame store, timer, scan position and output register.
`timescale 1ns / 1ps
`default_nettype none
module lmbps_dp #(
  parameter int ROW_COUNT  = 8,
  parameter int NUM_PLANES = 3,
  parameter int LINE_BYTES = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [lmbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lmbps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                   in_action,
  input  wire logic [1:0]                             in_wr_plane,
  input  wire logic [2:0]                             in_wr_row,
  input  wire logic [2:0]                             in_wr_byte,
  input  wire logic [7:0]                             in_wr_data,
  input  wire lmbps_pkg::ctl_cmd_t                    cmd,
  output lmbps_pkg::dp_stat_t                         stat,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [2:0]                                  out_row_select,
  output logic [1:0]                                  out_shown_plane,
  output logic [5:0]                                  out_column,
  output logic                                        out_data_bit,
  output logic                                        out_last
);
  import lmbps_pkg::*;

  localparam int DEPTH  = NUM_PLANES * ROW_COUNT * LINE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BYTE_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [7:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0] rd_data_r;
  logic       rd_valid_r;

  logic [7:0] plane0_period_r;
  logic [7:0] plane1_period_r;
  logic [7:0] plane2_period_r;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic [7:0] compare_r, compare_nxt;
  logic       matched_r, matched_nxt;
  logic [2:0] scan_row_r, scan_row_nxt;
  logic [1:0] scan_plane_r, scan_plane_nxt;
  logic [2:0] line_row_r;
  logic [1:0] line_plane_r;
  logic [BYTE_W-1:0] byte_idx_r;
  logic [2:0] bit_idx_r;
  logic [7:0] shift_r;

  logic              out_valid_r;
  logic [2:0]        out_row_r;
  logic [1:0]        out_plane_r;
  logic [5:0]        out_column_r;
  logic              out_bit_r;
  logic              out_last_r;

  logic              wr_in_range;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_in_range = (int'(in_wr_plane) < NUM_PLANES) && (int'(in_wr_row) < ROW_COUNT) &&
                       (int'(in_wr_byte) < LINE_BYTES);
  assign wr_en   = cmd.accept && (in_action == ACT_WRITE) && wr_in_range;
  assign wr_addr = ADDR_W'((int'(in_wr_plane) * ROW_COUNT + int'(in_wr_row)) * LINE_BYTES +
                           int'(in_wr_byte));
  assign rd_addr = ADDR_W'((int'(line_plane_r) * ROW_COUNT + int'(line_row_r)) * LINE_BYTES +
                           int'(byte_idx_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign stat.tick_match = (in_action == ACT_TICK) && (tick_count_r == compare_r);
  assign stat.bit_end    = (bit_idx_r == 3'd7);
  assign stat.byte_end   = (byte_idx_r == BYTE_W'(LINE_BYTES - 1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    tick_count_nxt = tick_count_r;
    compare_nxt    = compare_r;
    matched_nxt    = matched_r;
    scan_row_nxt   = scan_row_r;
    scan_plane_nxt = scan_plane_r;
    if (cfg_we && (cfg_index == REG_FIRST_PERIOD) && !matched_r) begin
      compare_nxt = cfg_wdata;
    end
    if (cmd.accept && (in_action == ACT_TICK)) begin
      if (cmd.start) begin
        tick_count_nxt = '0;
        matched_nxt    = 1'b1;
        if (scan_row_r == '0) begin
          unique case (scan_plane_r)
            2'd0: compare_nxt = plane0_period_r;
            2'd1: compare_nxt = plane1_period_r;
            2'd2: compare_nxt = plane2_period_r;
            default: compare_nxt = compare_r;
          endcase
        end
        if (scan_row_r == 3'(ROW_COUNT - 1)) begin
          scan_row_nxt = '0;
          if (scan_plane_r == 2'(NUM_PLANES - 1)) begin
            scan_plane_nxt = '0;
          end else begin
            scan_plane_nxt = scan_plane_r + 2'd1;
          end
        end else begin
          scan_row_nxt = scan_row_r + 3'd1;
        end
      end else begin
        tick_count_nxt = tick_count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane0_period_r <= RST_PLANE0_PERIOD;
      plane1_period_r <= RST_PLANE1_PERIOD;
      plane2_period_r <= RST_PLANE2_PERIOD;
      tick_count_r    <= '0;
      compare_r       <= RST_FIRST_PERIOD;
      matched_r       <= 1'b0;
      scan_row_r      <= '0;
      scan_plane_r    <= '0;
      byte_idx_r      <= '0;
      bit_idx_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PLANE0_PERIOD: plane0_period_r <= cfg_wdata;
          REG_PLANE1_PERIOD: plane1_period_r <= cfg_wdata;
          REG_PLANE2_PERIOD: plane2_period_r <= cfg_wdata;
          default: ;
        endcase
      end
      tick_count_r <= tick_count_nxt;
      compare_r    <= compare_nxt;
      matched_r    <= matched_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_plane_r <= scan_plane_nxt;
      if (cmd.start) begin
        byte_idx_r <= '0;
      end else if (cmd.next_byte) begin
        byte_idx_r <= byte_idx_r + BYTE_W'(1);
      end
      if (cmd.load) begin
        bit_idx_r <= '0;
      end else if (cmd.emit) begin
        bit_idx_r <= bit_idx_r + 3'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      line_row_r   <= scan_row_r;
      line_plane_r <= scan_plane_r;
    end
    if (cmd.load) begin
      shift_r <= rd_valid_r ? rd_data_r : 8'h00;
    end else if (cmd.emit) begin
      shift_r <= {1'b0, shift_r[7:1]};
    end
    if (cmd.emit) begin
      out_row_r    <= line_row_r;
      out_plane_r  <= line_plane_r;
      out_column_r <= {3'(byte_idx_r), bit_idx_r};
      out_bit_r    <= shift_r[0];
      out_last_r   <= stat.bit_end && stat.byte_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_select  = out_row_r;
  assign out_shown_plane = out_plane_r;
  assign out_column      = out_column_r;
  assign out_data_bit    = out_bit_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

FILE: design/led_matrix_bit_plane_scanner_core.sv
// Top level of the LED matrix bit-plane scanner.
//
// Input items either write one byte of the frame store or deliver one timer
// tick; a tick that does not match only advances the counter. A tick that
// matches keeps the input stalled while the line is sent, shifted out one bit
// per cycle unless the result side stalls: each byte takes one frame-store
// read through the single registered read port, one load into the shift
// register and eight shifts. One result item is emitted per shifted bit,
// LINE_BYTES*8 in all. The frame store is cleared at reset at once by one
// valid flag per entry; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_bit_plane_scanner_core #(
  parameter int ROW_COUNT  = 8,
  parameter int NUM_PLANES = 3,
  parameter int LINE_BYTES = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [lmbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lmbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_action,
  input  wire logic [1:0]                         in_wr_plane,
  input  wire logic [2:0]                         in_wr_row,
  input  wire logic [2:0]                         in_wr_byte,
  input  wire logic [7:0]                         in_wr_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_row_select,
  output logic [1:0]                              out_shown_plane,
  output logic [5:0]                              out_column,
  output logic                                    out_data_bit,
  output logic                                    out_last
);
  import lmbps_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lmbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmbps_dp #(
    .ROW_COUNT  (ROW_COUNT),
    .NUM_PLANES (NUM_PLANES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_wr_plane     (in_wr_plane),
    .in_wr_row       (in_wr_row),
    .in_wr_byte      (in_wr_byte),
    .in_wr_data      (in_wr_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_select  (out_row_select),
    .out_shown_plane (out_shown_plane),
    .out_column      (out_column),
    .out_data_bit    (out_data_bit),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: design/lmbps_checker.sv
// Port-level assertions for the scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lmbps_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_row_select,
  input wire logic [1:0] out_shown_plane,
  input wire logic [5:0] out_column,
  input wire logic       out_data_bit,
  input wire logic       out_last
);

  logic [5:0] col_exp_r;
  logic [5:0] col_exp_nxt;
  logic       out_fire;

  assign out_fire    = out_valid && !out_stall;
  assign col_exp_nxt = out_last ? 6'd0 : out_column + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_exp_r <= '0;
    end else if (out_fire) begin
      col_exp_r <= col_exp_nxt;
    end
  end

  `LMBPS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable({out_row_select, out_shown_plane, out_column, out_data_bit, out_last}), "stalled result item changed")

  `LMBPS_ASSERT(a_col_seq, clk, rst_n, out_fire |-> out_column == col_exp_r, "result column out of sequence")

  `LMBPS_ASSERT(a_line_stall, clk, rst_n, out_valid && !out_last |-> in_stall, "input accepted in the middle of a line")

  `LMBPS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind led_matrix_bit_plane_scanner_core lmbps_checker u_lmbps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_row_select  (out_row_select),
  .out_shown_plane (out_shown_plane),
  .out_column      (out_column),
  .out_data_bit    (out_data_bit),
  .out_last        (out_last)
);
`default_nettype wire
